// ----- sv/in_order_frame_reorder_buffer_macros.svh -----
// Assertion macros for the frame reorder buffer.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef IN_ORDER_FRAME_REORDER_BUFFER_MACROS_SVH
`define IN_ORDER_FRAME_REORDER_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define OFRB_ASSERT_IMPLIES(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("ofrb: same-cycle check failed");

// Next-cycle implication
`define OFRB_ASSERT_NEXT(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("ofrb: next-cycle check failed");

`else

`define OFRB_ASSERT_IMPLIES(label, ck, rn, pre, post)
`define OFRB_ASSERT_NEXT(label, ck, rn, pre, post)

`endif

`endif

// ----- sv/ofrb_pkg.sv -----
`default_nettype none

package ofrb_pkg;

    // Field widths
    localparam int MODE_W    = 2;
    localparam int NUM_W     = 24;
    localparam int HANDLE_W  = 32;
    localparam int COUNT_W   = 25;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = COUNT_W;

    // Defaults and limits
    localparam int WINDOW_DEPTH_DEFAULT = 32;
    localparam int MAX_RESULTS          = 32;

    // Input modes
    typedef enum logic [MODE_W-1:0] {
        MODE_ARRIVE = 2'd0,
        MODE_START  = 2'd1,
        MODE_STOP   = 2'd2
    } mode_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_RELEASE = 2'd0,
        KIND_REJECT  = 2'd1,
        KIND_ACK     = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_FRAME  = 1'b0,
        CFG_FRAMES_TOTAL = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- sv/ofrb_arrival_if.sv -----
`default_nettype none

interface ofrb_arrival_if;
    logic                            valid;
    logic                            ready;
    logic [ofrb_pkg::MODE_W-1:0]     mode;
    logic [ofrb_pkg::NUM_W-1:0]      frame_number;
    logic [ofrb_pkg::HANDLE_W-1:0]   frame_handle;

    modport source (output valid, output mode, output frame_number, output frame_handle,
                    input ready);
    modport sink   (input valid, input mode, input frame_number, input frame_handle,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/ofrb_result_if.sv -----
`default_nettype none

interface ofrb_result_if;
    logic                            valid;
    logic                            ready;
    logic [ofrb_pkg::KIND_W-1:0]     kind;
    logic [ofrb_pkg::NUM_W-1:0]      out_number;
    logic [ofrb_pkg::HANDLE_W-1:0]   out_handle;
    logic                            last_of_run;
    logic                            finished;

    modport source (output valid, output kind, output out_number, output out_handle,
                    output last_of_run, output finished, input ready);
    modport sink   (input valid, input kind, input out_number, input out_handle,
                    input last_of_run, input finished, output ready);
endinterface

`default_nettype wire

// ----- sv/in_order_frame_reorder_buffer.sv -----
// Channel    Role    Transfer when          Payload
// arrival    sink    valid & ready          mode, frame_number, frame_handle
// result     source  valid & ready          kind, out_number, out_handle, last_of_run, finished
// cfg        write   cfg_we high            cfg_index, cfg_data
//
// One item at a time. An arrival that releases nothing passes from S_IDLE through S_SCAN back to
// S_IDLE; one that releases frames alternates S_SCAN (read the handle memory at the expected slot)
// with S_READ (present the release). A stop or a rejection goes to S_EMIT; a start passes through
// S_MOD, which reduces first_frame modulo the window depth from its product with a reciprocal.
// Reset clears the window valid bits at once; the handle memory needs no clearing.
// A stall on the result side holds the sequencer; the output register frees the
// arrival side once its last result is loaded.
`default_nettype none

`include "in_order_frame_reorder_buffer_macros.svh"

module in_order_frame_reorder_buffer #(
    parameter int WINDOW_DEPTH = ofrb_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ofrb_arrival_if.sink                           arrival,
    ofrb_result_if.source                          result,
    input  wire logic                              cfg_we,
    input  wire logic [ofrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ofrb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NUM_W    = ofrb_pkg::NUM_W;
    localparam int HANDLE_W = ofrb_pkg::HANDLE_W;
    localparam int COUNT_W  = ofrb_pkg::COUNT_W;
    localparam int SW       = $clog2(WINDOW_DEPTH);
    localparam int TW       = SW + 2;
    localparam int NW       = $clog2(ofrb_pkg::MAX_RESULTS);
    // Slot offset caused by the number wrapping at 2^NUM_W
    localparam int WRAP_REM = (1 << NUM_W) % WINDOW_DEPTH;
    localparam int WRAP_ADJ = WINDOW_DEPTH - WRAP_REM;
    // Reciprocal of the window depth, exact for every NUM_W-bit number
    localparam int MW       = NUM_W + 1;
    localparam int PW       = NUM_W + MW;
    localparam int QSH      = NUM_W + SW;
    localparam longint unsigned RECIP =
        ((64'd1 << QSH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_EMIT = 5'b00100,
        S_SCAN = 5'b01000,
        S_READ = 5'b10000
    } state_t;

    // Control registers
    state_t                     state_reg, state_next;
    logic [NUM_W-1:0]           first_frame_reg, first_frame_next;
    logic [COUNT_W-1:0]         frames_total_reg, frames_total_next;
    logic                       active_reg, active_next;
    logic [NUM_W-1:0]           exp_reg, exp_next;
    logic [SW-1:0]              exp_slot_reg, exp_slot_next;
    logic [COUNT_W-1:0]         rel_reg, rel_next;
    logic [WINDOW_DEPTH-1:0]    valid_reg, valid_next;
    logic [NW-1:0]              burst_reg, burst_next;
    logic                       out_valid_reg, out_valid_next;

    // Payload registers
    ofrb_pkg::kind_t            pend_kind_reg, pend_kind_next;
    logic [NUM_W-1:0]           pend_number_reg, pend_number_next;
    logic [HANDLE_W-1:0]        pend_handle_reg, pend_handle_next;
    ofrb_pkg::kind_t            out_kind_reg, out_kind_next;
    logic [NUM_W-1:0]           out_number_reg, out_number_next;
    logic [HANDLE_W-1:0]        out_handle_reg, out_handle_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_fin_reg, out_fin_next;
    logic [PW-1:0]              mod_prod_reg, mod_prod_next;

    // Datapath
    logic                       arr_accept;
    logic                       out_free;
    logic [NUM_W-1:0]           offset;
    logic                       in_window;
    logic                       num_wrapped;
    logic [TW-1:0]              slot_sum;
    logic [TW-1:0]              slot_red;
    logic [SW-1:0]              slot_idx;
    logic                       reject;
    logic [PW-1:0]              mod_prod;
    logic [SW:0]                mod_quot;
    logic [SW:0]                mod_rem;
    logic [COUNT_W-1:0]         rel_inc;
    logic                       rel_fin;
    logic [SW-1:0]              slot_inc;
    logic [WINDOW_DEPTH-1:0]    cur_mask;
    logic [WINDOW_DEPTH-1:0]    valid_left;
    logic                       rel_last;
    logic                       ram_we;
    logic [HANDLE_W-1:0]        ram_rdata;
    logic                       slot_in_range;

    assign arrival.ready = (state_reg == S_IDLE);
    assign arr_accept    = arrival.valid && arrival.ready;
    assign out_free      = !out_valid_reg || result.ready;

    // Locate the arrival slot relative to the expected slot
    assign offset      = arrival.frame_number - exp_reg;
    assign in_window   = offset < NUM_W'(WINDOW_DEPTH);
    assign num_wrapped = arrival.frame_number < exp_reg;
    assign slot_sum    = TW'(exp_slot_reg) + TW'(offset[SW-1:0])
                       + (num_wrapped ? TW'(WRAP_ADJ) : TW'(0));

    always_comb
    begin
        if (slot_sum >= TW'(2 * WINDOW_DEPTH))
        begin
            slot_red = slot_sum - TW'(2 * WINDOW_DEPTH);
        end
        else if (slot_sum >= TW'(WINDOW_DEPTH))
        begin
            slot_red = slot_sum - TW'(WINDOW_DEPTH);
        end
        else
        begin
            slot_red = slot_sum;
        end
    end

    assign slot_idx = slot_red[SW-1:0];
    assign reject   = !active_reg || !in_window || valid_reg[slot_idx];

    // Reduce first_frame modulo the window depth: quotient from the reciprocal product,
    // remainder from the low bits only
    assign mod_prod = PW'(first_frame_reg) * PW'(RECIP);
    assign mod_quot = mod_prod_reg[QSH +: SW+1];
    assign mod_rem  = exp_reg[SW:0] - (mod_quot * (SW+1)'(WINDOW_DEPTH));

    // Release of the frame in the expected slot
    assign rel_inc  = rel_reg + COUNT_W'(1);
    assign rel_fin  = (frames_total_reg != '0) && (rel_inc == frames_total_reg);
    assign slot_inc = (exp_reg == '1) ? '0 :
                      ((exp_slot_reg == SW'(WINDOW_DEPTH - 1)) ? '0 :
                       exp_slot_reg + SW'(1));
    assign cur_mask   = {{(WINDOW_DEPTH-1){1'b0}}, 1'b1} << exp_slot_reg;
    assign valid_left = valid_reg & ~cur_mask;
    assign rel_last   = rel_fin || (burst_reg == NW'(ofrb_pkg::MAX_RESULTS - 1))
                      || !valid_left[slot_inc];

    assign slot_in_range = {1'b0, exp_slot_reg} < (SW+1)'(WINDOW_DEPTH);

    assign ram_we = arr_accept && (arrival.mode == ofrb_pkg::MODE_ARRIVE) && !reject;

    ofrb_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_handle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (arrival.frame_handle),
        .raddr (exp_slot_reg),
        .rdata (ram_rdata)
    );

    // Sequencer and window state
    always_comb
    begin
        state_next        = state_reg;
        first_frame_next  = first_frame_reg;
        frames_total_next = frames_total_reg;
        active_next       = active_reg;
        exp_next          = exp_reg;
        exp_slot_next     = exp_slot_reg;
        rel_next          = rel_reg;
        valid_next        = valid_reg;
        burst_next        = burst_reg;
        mod_prod_next     = mod_prod_reg;
        pend_kind_next    = pend_kind_reg;
        pend_number_next  = pend_number_reg;
        pend_handle_next  = pend_handle_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_kind_next     = out_kind_reg;
        out_number_next   = out_number_reg;
        out_handle_next   = out_handle_reg;
        out_last_next     = out_last_reg;
        out_fin_next      = out_fin_reg;

        // Configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                ofrb_pkg::CFG_FIRST_FRAME:  first_frame_next  = cfg_data[NUM_W-1:0];
                ofrb_pkg::CFG_FRAMES_TOTAL: frames_total_next = cfg_data;
                default:                    first_frame_next  = first_frame_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (arr_accept)
                begin
                    unique case (arrival.mode)
                        ofrb_pkg::MODE_START:
                        begin
                            active_next      = 1'b1;
                            valid_next       = '0;
                            exp_next         = first_frame_reg;
                            exp_slot_next    = '0;
                            rel_next         = '0;
                            mod_prod_next    = mod_prod;
                            pend_kind_next   = ofrb_pkg::KIND_ACK;
                            pend_number_next = '0;
                            pend_handle_next = '0;
                            state_next       = S_MOD;
                        end
                        ofrb_pkg::MODE_STOP:
                        begin
                            active_next      = 1'b0;
                            valid_next       = '0;
                            pend_kind_next   = ofrb_pkg::KIND_ACK;
                            pend_number_next = '0;
                            pend_handle_next = '0;
                            state_next       = S_EMIT;
                        end
                        ofrb_pkg::MODE_ARRIVE:
                        begin
                            if (reject)
                            begin
                                pend_kind_next   = ofrb_pkg::KIND_REJECT;
                                pend_number_next = arrival.frame_number;
                                pend_handle_next = arrival.frame_handle;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                valid_next[slot_idx] = 1'b1;
                                burst_next           = '0;
                                state_next           = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                exp_slot_next = mod_rem[SW-1:0];
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_number_next = pend_number_reg;
                    out_handle_next = pend_handle_reg;
                    out_last_next   = 1'b1;
                    out_fin_next    = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // Handle memory reads the expected slot this cycle
                state_next = valid_reg[exp_slot_reg] ? S_READ : S_IDLE;
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = ofrb_pkg::KIND_RELEASE;
                    out_number_next = exp_reg;
                    out_handle_next = ram_rdata;
                    out_last_next   = rel_last;
                    out_fin_next    = rel_fin;
                    rel_next        = rel_inc;
                    exp_next        = exp_reg + NUM_W'(1);
                    exp_slot_next   = slot_inc;
                    burst_next      = burst_reg + NW'(1);
                    valid_next      = rel_fin ? '0 : valid_left;
                    if (rel_fin)
                    begin
                        active_next = 1'b0;
                    end
                    state_next = rel_last ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            first_frame_reg  <= '0;
            frames_total_reg <= COUNT_W'(1);
            active_reg       <= 1'b0;
            exp_reg          <= '0;
            exp_slot_reg     <= '0;
            rel_reg          <= '0;
            valid_reg        <= '0;
            burst_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_frame_reg  <= first_frame_next;
            frames_total_reg <= frames_total_next;
            active_reg       <= active_next;
            exp_reg          <= exp_next;
            exp_slot_reg     <= exp_slot_next;
            rel_reg          <= rel_next;
            valid_reg        <= valid_next;
            burst_reg        <= burst_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pend_kind_reg   <= pend_kind_next;
        pend_number_reg <= pend_number_next;
        pend_handle_reg <= pend_handle_next;
        out_kind_reg    <= out_kind_next;
        out_number_reg  <= out_number_next;
        out_handle_reg  <= out_handle_next;
        out_last_reg    <= out_last_next;
        out_fin_reg     <= out_fin_next;
        mod_prod_reg    <= mod_prod_next;
    end

    // Drive the result transfer
    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.out_number  = out_number_reg;
    assign result.out_handle  = out_handle_reg;
    assign result.last_of_run = out_last_reg;
    assign result.finished    = out_fin_reg;

    `OFRB_ASSERT_IMPLIES(a_fin_is_last, clk, rst_n, out_valid_reg && out_fin_reg, out_last_reg)
    `OFRB_ASSERT_IMPLIES(a_read_slot_valid, clk, rst_n, state_reg == S_READ, valid_reg[exp_slot_reg])
    `OFRB_ASSERT_NEXT(a_finish_clears, clk, rst_n, state_reg == S_READ && out_free && rel_fin, !active_reg && valid_reg == '0)
    `OFRB_ASSERT_IMPLIES(a_slot_in_range, clk, rst_n, active_reg, slot_in_range)

endmodule

`default_nettype wire

// ----- sv/ofrb_ram.sv -----
`default_nettype none

module ofrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
